>>> sv/dmg_pkg.sv
// Shared types and codes for the depth-first maze generator.
// Used by the top level and by the port checker; depends on nothing.
package dmg_pkg;

	// Input tuser: what the beat asks for.
	localparam logic OP_GENERATE = 1'b0;
	localparam logic OP_READ     = 1'b1;

	// Output tuser: what the result beat answers.
	localparam logic KIND_GEN_DONE = 1'b0;
	localparam logic KIND_TILE     = 1'b1;

	// Configuration register indexes.
	localparam logic REG_ROWS = 1'b0;
	localparam logic REG_COLS = 1'b1;

	// Neighbour directions, in candidate order.
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_DOWN  = 2'd1;
	localparam logic [1:0] DIR_LEFT  = 2'd2;
	localparam logic [1:0] DIR_RIGHT = 2'd3;

	localparam logic [5:0] DIM_RESET = 6'd25;
	localparam logic [5:0] DIM_MIN   = 6'd5;

	typedef logic [5:0] dim_t;

endpackage

>>> sv/dfs_maze_generator_top.sv
// Maze generator top level: recursive backtracker over a tile map, visited map and cell stack.
// Depends on dmg_pkg; the maze state lives in three single-port synchronous memories.
//
// Reads: an accepted read beat addresses the tile memory, and the registered read data then
// loads the output register; no new beat is taken while a read is pending. A generate beat
// runs a clearing sweep over all MAX_DIM*MAX_DIM tiles, then opens cells and backtracks, and
// the visited memory is read once per neighbour before each choice of direction.
// Reset clears all control state; the tile map then reads as all walls until the first
// generate, through a map-valid flag, so no clearing pass runs after reset.
module dfs_maze_generator_top
	import dmg_pkg::*;
#(
	parameter int MAX_DIM = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input stream.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // seed [31:0], tile_row [37:32], tile_col [43:38], zero fill
	input  logic        s_tuser,   // operation
	// Result stream.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // is_wall [0], out_of_range [1], zero fill
	output logic        m_tuser,   // result_kind
	// Configuration writes.
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [5:0]  cfg_data
);

	localparam int HALF  = MAX_DIM / 2;
	localparam int CELLS = HALF * HALF;
	localparam int TILES = MAX_DIM * MAX_DIM;
	localparam int CW    = $clog2(HALF);
	localparam int VAW   = $clog2(CELLS);
	localparam int SAW   = $clog2(CELLS);
	localparam int TAW   = $clog2(TILES);
	localparam int DPW   = $clog2(CELLS + 1);
	// Largest odd size that still fits below MAX_DIM.
	localparam int LIM_RAW = MAX_DIM - 1;
	localparam int LIM     = (LIM_RAW % 2 == 0) ? LIM_RAW - 1 : LIM_RAW;
	localparam logic [5:0] LIM6 = (LIM > 63) ? 6'd63 : 6'(LIM);
	localparam logic [TAW-1:0] TILE_LAST = TAW'(TILES - 1);

	typedef struct packed {
		logic [CW-1:0] cy;
		logic [CW-1:0] cx;
	} cell_t;

	// Sequencer codes.
	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CLR    = 4'd1;
	localparam logic [3:0] S_INIT   = 4'd2;
	localparam logic [3:0] S_POP_RD = 4'd3;
	localparam logic [3:0] S_POP_WT = 4'd4;
	localparam logic [3:0] S_VIS    = 4'd5;
	localparam logic [3:0] S_VCHK   = 4'd6;
	localparam logic [3:0] S_DECIDE = 4'd7;
	localparam logic [3:0] S_PICK   = 4'd8;
	localparam logic [3:0] S_WR1    = 4'd9;
	localparam logic [3:0] S_WR2    = 4'd10;
	localparam logic [3:0] S_DONE   = 4'd11;

	// Effective grid size: forced odd, at least five, and capped by the map size.
	function automatic dim_t eff_dim(input dim_t raw);
		dim_t v;
		v = raw | 6'd1;
		if (v < DIM_MIN) v = DIM_MIN;
		if (int'(v) > LIM) v = LIM6;
		return v;
	endfunction

	function automatic logic [31:0] xorshift(input logic [31:0] x);
		logic [31:0] t;
		t = x ^ (x << 13);
		t = t ^ (t >> 17);
		t = t ^ (t << 5);
		return t;
	endfunction

	// Remainder by three, folding on powers of two that are one modulo three.
	function automatic logic [1:0] mod3(input logic [31:0] x);
		logic [16:0] s1;
		logic [9:0]  s2;
		logic [6:0]  s3;
		logic [4:0]  s4;
		logic [3:0]  s5;
		logic [2:0]  s6;
		logic [1:0]  r;
		s1 = {1'b0, x[31:16]} + {1'b0, x[15:0]};
		s2 = {1'b0, s1[16:8]} + {2'b0, s1[7:0]};
		s3 = {1'b0, s2[9:4]} + {3'b0, s2[3:0]};
		s4 = s3[6:2] + {3'b0, s3[1:0]};
		s5 = {1'b0, s4[4:2]} + {2'b0, s4[1:0]};
		s6 = {1'b0, s5[3:2]} + {1'b0, s5[1:0]};
		case (s6)
			3'd0, 3'd3: r = 2'd0;
			3'd1, 3'd4: r = 2'd1;
			3'd2, 3'd5: r = 2'd2;
			default:    r = 2'd0;
		endcase
		return r;
	endfunction

	function automatic logic [TAW-1:0] taddr(input int ty, input int tx);
		return TAW'(ty * MAX_DIM + tx);
	endfunction

	function automatic logic [VAW-1:0] vidx(input cell_t c);
		return VAW'(int'(c.cy) * HALF + int'(c.cx));
	endfunction

	function automatic cell_t nb_of(input cell_t c, input logic [1:0] k);
		cell_t n;
		n = c;
		unique case (k)
			DIR_UP:    n.cy = c.cy - CW'(1);
			DIR_DOWN:  n.cy = c.cy + CW'(1);
			DIR_LEFT:  n.cx = c.cx - CW'(1);
			DIR_RIGHT: n.cx = c.cx + CW'(1);
			default:   n = c;
		endcase
		return n;
	endfunction

	// Configuration.
	dim_t rows_q, cols_q;
	dim_t rows_eff, cols_eff;

	// Control state.
	logic [3:0]     state_q;
	logic [TAW-1:0] clr_addr_q;
	cell_t          cur_q, nb_q;
	logic [1:0]     vk_q, vk_s1, pick_k_q;
	logic           vrd_s1;
	logic [3:0]     vis_q, cand_q;
	logic [2:0]     cnt_q;
	logic [DPW-1:0] depth_q, depth_m1;
	logic [31:0]    prng_q;
	logic           gen_q;
	logic           rd_pend_s1, rd_oor_s1;
	logic           out_valid_q, out_kind_q, out_wall_q, out_oor_q;

	// Memory ports.
	logic           tile_we, tile_wd, tile_rd_q;
	logic [TAW-1:0] tile_addr;
	logic           vis_we, vis_wd, vis_rd_q;
	logic [VAW-1:0] vis_addr;
	logic           stk_we;
	logic [SAW-1:0] stk_addr;
	cell_t          stk_wd, stk_rd_q;

	logic           tile_mem [TILES];
	logic           vis_mem  [CELLS];
	cell_t          stk_mem  [CELLS];

	// Combinational helpers.
	logic [3:0] inb, cand;
	logic [2:0] cnt;
	logic       s_acc, out_free, load_rd, load_gen, read_oor;
	logic [1:0] pick_val, pick_k;
	logic [5:0] in_row, in_col;
	int         cur_ty, cur_tx, wall_ty, wall_tx;

	assign rows_eff = eff_dim(rows_q);
	assign cols_eff = eff_dim(cols_q);
	assign in_row   = s_tdata[37:32];
	assign in_col   = s_tdata[43:38];
	assign depth_m1 = depth_q - DPW'(1);

	// The output register frees up either when empty or when its beat leaves this cycle.
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == S_IDLE) && !rd_pend_s1 && out_free;
	assign s_acc    = s_tvalid && s_tready;
	assign load_rd  = rd_pend_s1;
	assign load_gen = (state_q == S_DONE) && out_free;
	assign read_oor = (in_row >= rows_eff) || (in_col >= cols_eff);

	// Neighbour tests around the current cell; tile coordinates are 2*c+1.
	always_comb begin
		inb[DIR_UP]    = cur_q.cy != '0;
		inb[DIR_DOWN]  = (int'(cur_q.cy) * 2 + 4) < int'(rows_eff);
		inb[DIR_LEFT]  = cur_q.cx != '0;
		inb[DIR_RIGHT] = (int'(cur_q.cx) * 2 + 4) < int'(cols_eff);
		cand = inb & ~vis_q;
		cnt  = 3'($countones(cand));
	end

	// The pick is the generator value modulo the candidate count, then the
	// pick-th candidate in direction order.
	always_comb begin
		logic [1:0] seen;
		logic       found;
		case (cnt_q)
			3'd2:    pick_val = {1'b0, prng_q[0]};
			3'd3:    pick_val = mod3(prng_q);
			3'd4:    pick_val = prng_q[1:0];
			default: pick_val = 2'd0;
		endcase
		seen   = 2'd0;
		found  = 1'b0;
		pick_k = 2'd0;
		for (int k = 0; k < 4; k++) begin
			if (cand_q[k] && !found) begin
				if (seen == pick_val) begin
					pick_k = 2'(k);
					found  = 1'b1;
				end else begin
					seen = seen + 2'd1;
				end
			end
		end
	end

	// Wall tile between the current cell and the chosen neighbour.
	always_comb begin
		cur_ty  = int'(cur_q.cy) * 2 + 1;
		cur_tx  = int'(cur_q.cx) * 2 + 1;
		wall_ty = cur_ty;
		wall_tx = cur_tx;
		unique case (pick_k_q)
			DIR_UP:    wall_ty = cur_ty - 1;
			DIR_DOWN:  wall_ty = cur_ty + 1;
			DIR_LEFT:  wall_tx = cur_tx - 1;
			DIR_RIGHT: wall_tx = cur_tx + 1;
			default:   wall_ty = cur_ty;
		endcase
	end

	// Memory port steering.
	always_comb begin
		tile_we   = 1'b0;
		tile_wd   = 1'b1;
		tile_addr = '0;
		vis_we    = 1'b0;
		vis_wd    = 1'b0;
		vis_addr  = '0;
		stk_we    = 1'b0;
		stk_addr  = '0;
		stk_wd    = nb_q;
		unique case (state_q)
			S_IDLE: begin
				if (!read_oor) tile_addr = taddr(int'(in_row), int'(in_col));
			end
			S_CLR: begin
				tile_we   = 1'b1;
				tile_wd   = 1'b1;
				tile_addr = clr_addr_q;
				if (int'(clr_addr_q) < CELLS) begin
					vis_we   = 1'b1;
					vis_addr = clr_addr_q[VAW-1:0];
				end
			end
			S_INIT: begin
				tile_we   = 1'b1;
				tile_wd   = 1'b0;
				tile_addr = taddr(1, 1);
				vis_we    = 1'b1;
				vis_wd    = 1'b1;
				stk_we    = 1'b1;
				stk_wd    = '0;
			end
			S_POP_RD: stk_addr = depth_m1[SAW-1:0];
			S_VIS: begin
				if (inb[vk_q]) vis_addr = vidx(nb_of(cur_q, vk_q));
			end
			S_WR1: begin
				tile_we   = 1'b1;
				tile_wd   = 1'b0;
				tile_addr = taddr(wall_ty, wall_tx);
				vis_we    = 1'b1;
				vis_wd    = 1'b1;
				vis_addr  = vidx(nb_q);
				stk_we    = 1'b1;
				stk_addr  = depth_q[SAW-1:0];
			end
			S_WR2: begin
				tile_we   = 1'b1;
				tile_wd   = 1'b0;
				tile_addr = taddr(int'(nb_q.cy) * 2 + 1, int'(nb_q.cx) * 2 + 1);
			end
			default: tile_we = 1'b0;
		endcase
	end

	// Memories: one port each, read data registered.
	always_ff @(posedge clk) begin
		if (tile_we) tile_mem[tile_addr] <= tile_wd;
		tile_rd_q <= tile_mem[tile_addr];
	end

	always_ff @(posedge clk) begin
		if (vis_we) vis_mem[vis_addr] <= vis_wd;
		vis_rd_q <= vis_mem[vis_addr];
	end

	always_ff @(posedge clk) begin
		if (stk_we) stk_mem[stk_addr] <= stk_wd;
		stk_rd_q <= stk_mem[stk_addr];
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIM_RESET;
			cols_q <= DIM_RESET;
		end else if (cfg_we) begin
			if (cfg_index == REG_ROWS) rows_q <= cfg_data;
			if (cfg_index == REG_COLS) cols_q <= cfg_data;
		end
	end

	// Sequencer. The current cell is always the top of the stack, counted in depth_q.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			clr_addr_q <= '0;
			cur_q      <= '0;
			nb_q       <= '0;
			vk_q       <= '0;
			vk_s1      <= '0;
			vrd_s1     <= 1'b0;
			vis_q      <= '0;
			cand_q     <= '0;
			cnt_q      <= '0;
			pick_k_q   <= '0;
			depth_q    <= '0;
			prng_q     <= 32'd1;
			gen_q      <= 1'b0;
			rd_pend_s1 <= 1'b0;
			rd_oor_s1  <= 1'b0;
		end else begin
			rd_pend_s1 <= s_acc && (s_tuser == OP_READ);
			rd_oor_s1  <= read_oor;
			vrd_s1     <= (state_q == S_VIS);
			vk_s1      <= vk_q;
			if (vrd_s1) vis_q[vk_s1] <= vis_rd_q;
			unique case (state_q)
				S_IDLE: begin
					if (s_acc && (s_tuser == OP_GENERATE)) begin
						prng_q     <= (s_tdata[31:0] == 32'd0) ? 32'd1 : s_tdata[31:0];
						clr_addr_q <= '0;
						state_q    <= S_CLR;
					end
				end
				S_CLR: begin
					clr_addr_q <= clr_addr_q + TAW'(1);
					if (clr_addr_q == TILE_LAST) state_q <= S_INIT;
				end
				S_INIT: begin
					gen_q   <= 1'b1;
					depth_q <= DPW'(1);
					cur_q   <= '0;
					vk_q    <= '0;
					state_q <= S_VIS;
				end
				S_POP_RD: state_q <= S_POP_WT;
				S_POP_WT: begin
					cur_q   <= stk_rd_q;
					vk_q    <= '0;
					state_q <= S_VIS;
				end
				S_VIS: begin
					vk_q <= vk_q + 2'd1;
					if (vk_q == DIR_RIGHT) state_q <= S_VCHK;
				end
				S_VCHK: state_q <= S_DECIDE;
				S_DECIDE: begin
					if (cnt == 3'd0) begin
						depth_q <= depth_m1;
						state_q <= (depth_q == DPW'(1)) ? S_DONE : S_POP_RD;
					end else begin
						prng_q  <= xorshift(prng_q);
						cand_q  <= cand;
						cnt_q   <= cnt;
						state_q <= S_PICK;
					end
				end
				S_PICK: begin
					pick_k_q <= pick_k;
					nb_q     <= nb_of(cur_q, pick_k);
					state_q  <= S_WR1;
				end
				S_WR1: begin
					depth_q <= depth_q + DPW'(1);
					state_q <= S_WR2;
				end
				S_WR2: begin
					cur_q   <= nb_q;
					vk_q    <= '0;
					state_q <= S_VIS;
				end
				S_DONE: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output register. Tiles read as walls until the first maze has been built.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_rd || load_gen) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_rd) begin
			out_kind_q <= KIND_TILE;
			out_oor_q  <= rd_oor_s1;
			out_wall_q <= rd_oor_s1 || !gen_q || tile_rd_q;
		end else if (load_gen) begin
			out_kind_q <= KIND_GEN_DONE;
			out_oor_q  <= 1'b0;
			out_wall_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {6'b0, out_oor_q, out_wall_q};

endmodule

>>> sv/dmg_checker.sv
// Port-level checker for the maze generator top level, attached by a bind statement.
// Depends on dmg_pkg for the operation and result codes.
module dmg_checker
	import dmg_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        s_tuser,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [7:0]  m_tdata,
	input logic        m_tuser
);

	// A stalled result beat holds its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result beat changed while stalled");

	// A read outside the grid always reports a wall.
	a_oor_wall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_TILE) && m_tdata[1] |-> m_tdata[0])
		else $error("out-of-range read without wall bit");

	// A finished generation carries no flags.
	a_gen_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_GEN_DONE) |-> (m_tdata[1:0] == 2'b00))
		else $error("generation result carries flags");

	// A read answer follows the read beat through the registered tile read and the output register.
	a_read_lat: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_READ) |-> ##2 m_tvalid)
		else $error("read answer missing");

	// A generate beat makes the block busy at once.
	a_gen_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == OP_GENERATE) |=> !s_tready)
		else $error("input accepted during generation");

endmodule

bind dfs_maze_generator_top dmg_checker u_dmg_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
